// ===== hdl/omt_pkg.sv =====
// ----------------------------------------------------------------------------
// omt_pkg
// shared constants, types and the modifier key table of the tracker
// ----------------------------------------------------------------------------
package omt_pkg;

   // down list geometry
   localparam int unsigned DOWN_DEPTH = 16;
   localparam int unsigned ADDR_W     = $clog2(DOWN_DEPTH);
   localparam int unsigned CNT_W      = $clog2(DOWN_DEPTH + 1);

   // held list geometry
   localparam int unsigned MAX_HELD = 4;
   localparam int unsigned HLEN_W   = 3;

   // word field widths
   localparam int unsigned FUNC_W = 2;
   localparam int unsigned DEV_W  = 8;
   localparam int unsigned CODE_W = 10;
   localparam int unsigned IDX_W  = 3;
   localparam int unsigned KIND_W = 2;
   localparam int unsigned NUM_KEYS = 8;

   // modifier key codes
   localparam logic [CODE_W-1:0] SUPER_L_CODE = 10'd125;
   localparam logic [CODE_W-1:0] SUPER_R_CODE = 10'd126;
   localparam logic [CODE_W-1:0] CTRL_L_CODE  = 10'd29;
   localparam logic [CODE_W-1:0] CTRL_R_CODE  = 10'd97;
   localparam logic [CODE_W-1:0] ALT_L_CODE   = 10'd56;
   localparam logic [CODE_W-1:0] ALT_R_CODE   = 10'd100;
   localparam logic [CODE_W-1:0] SHIFT_L_CODE = 10'd42;
   localparam logic [CODE_W-1:0] SHIFT_R_CODE = 10'd54;

   // table index -> key code; kind is index / 2
   localparam logic [CODE_W-1:0] KEY_TABLE [NUM_KEYS] = '{
      SUPER_L_CODE, SUPER_R_CODE, CTRL_L_CODE, CTRL_R_CODE,
      ALT_L_CODE, ALT_R_CODE, SHIFT_L_CODE, SHIFT_R_CODE
   };

   typedef enum logic [FUNC_W-1:0] {
      FUNC_PRESS     = 2'd0,
      FUNC_RELEASE   = 2'd1,
      FUNC_FORGET    = 2'd2,
      FUNC_RECONCILE = 2'd3
   } func_type;

   // one down list entry
   typedef struct packed {
      logic [DEV_W-1:0] device;
      logic [IDX_W-1:0] idx;
   } entry_type;

   localparam int unsigned ENTRY_W = $bits(entry_type);

   // sequencer -> held list unit
   typedef struct packed {
      logic                                commit;
      logic [MAX_HELD-1:0]                 seen;
      logic [MAX_HELD-1:0][KIND_W-1:0]     order;
      logic [HLEN_W-1:0]                   order_len;
   } held_ctl_type;

   // held list unit -> sequencer
   typedef struct packed {
      logic                                changed;
      logic [HLEN_W-1:0]                   count;
      logic [MAX_HELD-1:0][KIND_W-1:0]     list;
   } held_rpt_type;

   // {hit, table index} for a raw key code
   function automatic logic [IDX_W:0] key_lookup(input logic [CODE_W-1:0] code);
      logic [IDX_W:0] res;
      res = '0;
      for (int i = 0; i < NUM_KEYS; i++) begin
         if (code == KEY_TABLE[i]) begin
            res = {1'b1, IDX_W'(i)};
         end
      end
      return res;
   endfunction

endpackage

// ===== hdl/omt_if.sv =====
// ----------------------------------------------------------------------------
// omt_if
// valid/ready channels for request and response words
// ----------------------------------------------------------------------------
interface omt_req_if import omt_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [FUNC_W-1:0] func;
   logic [DEV_W-1:0]  device;
   logic [CODE_W-1:0] key_code;
   logic [7:0]        down_mask;
   logic              key_taken;

   modport source (output valid, func, device, key_code, down_mask, key_taken,
                   input ready);
   modport sink   (input valid, func, device, key_code, down_mask, key_taken,
                   output ready);
endinterface

interface omt_rsp_if import omt_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              changed;
   logic [HLEN_W-1:0] held_count;
   logic [KIND_W-1:0] held_first;
   logic [KIND_W-1:0] held_second;
   logic [KIND_W-1:0] held_third;
   logic [KIND_W-1:0] held_fourth;
   logic              taken_flag;
   logic              overflow;

   modport source (output valid, changed, held_count, held_first, held_second,
                          held_third, held_fourth, taken_flag, overflow,
                   input ready);
   modport sink   (input valid, changed, held_count, held_first, held_second,
                         held_third, held_fourth, taken_flag, overflow,
                   output ready);
endinterface

// ===== hdl/ordered_modifier_tracker_core.sv =====
// ----------------------------------------------------------------------------
// ordered_modifier_tracker_core
// tracks modifier keys held on several devices: an ordered down list of
// (device, key) pairs in ram and a stable ordered list of held kinds
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake            word
//  req_ch    in   valid/ready          func, device, key_code, down_mask, key_taken
//  rsp_ch    out  valid/ready          changed, held_count, held_*, taken_flag, overflow
//
//  one word in, one word out; a word walks the down list ram through its read port,
//  compacting out the dropped pairs, then appends its keys, then commits; the next
//  word is accepted only after that commit
//  the response register lets a new request start while the last response waits
//  a finished item stalls before commit only if the response register is still full
//  synchronous active high reset clears the down count and held length; no ram sweep
//
module ordered_modifier_tracker_core import omt_pkg::*; (
   input logic       clock,
   input logic       reset,
   omt_req_if.sink   req_ch,
   omt_rsp_if.source rsp_ch
);

   typedef enum logic [3:0] {
      ST_IDLE    = 4'b0001,
      ST_SCAN    = 4'b0010,
      ST_APPEND  = 4'b0100,
      ST_REFRESH = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   // item context
   logic [DEV_W-1:0]    dev_ff, dev_in;
   logic [NUM_KEYS-1:0] kill_ff, kill_in;       // table bits removed for the device
   logic [NUM_KEYS-1:0] add_ff, add_in;         // table bits to append
   logic [NUM_KEYS-1:0] present_ff, present_in; // kept bits of the device
   logic                taken_ff, taken_in;
   logic                ovf_ff, ovf_in;

   // down list pointers
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic             pend_ff, pend_in;           // ram read data valid this cycle

   // kinds produced by the new down list, in first occurrence order
   logic [MAX_HELD-1:0]             seen_ff, seen_in;
   logic [MAX_HELD-1:0][KIND_W-1:0] order_ff, order_in;
   logic [HLEN_W-1:0]               order_len_ff, order_len_in;

   // response register
   logic                            rsp_valid_ff, rsp_valid_in;
   held_rpt_type                    rpt_ff;
   logic                            rsp_taken_ff, rsp_ovf_ff;

   // ram port
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   entry_type         wr_data;
   logic [ADDR_W-1:0] rd_addr;
   logic [ENTRY_W-1:0] rd_data;
   entry_type          rd_entry;

   // held list unit
   held_ctl_type held_ctl;
   held_rpt_type held_rpt;
   logic         commit;

   // decode helpers
   logic [IDX_W:0]      lookup;
   logic [NUM_KEYS-1:0] key_bit;
   logic                scan_more;
   logic                kill_hit;
   logic [NUM_KEYS-1:0] low_bit;
   logic [IDX_W-1:0]    low_idx;
   logic                note_en;
   logic [KIND_W-1:0]   note_kind;

   assign rd_entry = entry_type'(rd_data);
   assign lookup   = key_lookup(req_ch.key_code);
   assign key_bit  = lookup[IDX_W] ? (NUM_KEYS'(1) << lookup[IDX_W-1:0]) : '0;
   assign scan_more = rd_ptr_ff < count_ff;
   assign kill_hit  = (rd_entry.device == dev_ff) && kill_ff[rd_entry.idx];
   assign low_bit   = add_ff & (~add_ff + NUM_KEYS'(1));
   assign commit    = (state_ff == ST_REFRESH) && (!rsp_valid_ff || rsp_ch.ready);

   always_comb begin
      low_idx = '0;
      for (int i = 0; i < NUM_KEYS; i++) begin
         if (low_bit[i]) begin
            low_idx = IDX_W'(i);
         end
      end
   end

   assign req_ch.ready = (state_ff == ST_IDLE);

   // sequencer
   always_comb begin
      state_in     = state_ff;
      dev_in       = dev_ff;
      kill_in      = kill_ff;
      add_in       = add_ff;
      present_in   = present_ff;
      taken_in     = taken_ff;
      ovf_in       = ovf_ff;
      count_in     = count_ff;
      rd_ptr_in    = rd_ptr_ff;
      wr_ptr_in    = wr_ptr_ff;
      pend_in      = 1'b0;
      seen_in      = seen_ff;
      order_in     = order_ff;
      order_len_in = order_len_ff;
      wr_en        = 1'b0;
      wr_addr      = wr_ptr_ff[ADDR_W-1:0];
      wr_data      = rd_entry;
      rd_addr      = rd_ptr_ff[ADDR_W-1:0];
      note_en      = 1'b0;
      note_kind    = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               dev_in       = req_ch.device;
               taken_in     = req_ch.key_taken;
               ovf_in       = 1'b0;
               present_in   = '0;
               rd_ptr_in    = '0;
               wr_ptr_in    = '0;
               seen_in      = '0;
               order_len_in = '0;
               case (func_type'(req_ch.func))
                  FUNC_PRESS: begin
                     kill_in = '0;
                     add_in  = key_bit;
                  end
                  FUNC_RELEASE: begin
                     kill_in = key_bit;
                     add_in  = '0;
                  end
                  FUNC_FORGET: begin
                     kill_in = '1;
                     add_in  = '0;
                  end
                  FUNC_RECONCILE: begin
                     kill_in = ~req_ch.down_mask;
                     add_in  = req_ch.down_mask;
                  end
                  default: begin
                     kill_in = '0;
                     add_in  = '0;
                  end
               endcase
               state_in = ST_SCAN;
            end
         end

         ST_SCAN: begin
            // issue the next read while compacting the word read last cycle
            if (scan_more) begin
               rd_ptr_in = rd_ptr_ff + 1'b1;
               pend_in   = 1'b1;
            end
            if (pend_ff && !kill_hit) begin
               wr_en     = 1'b1;
               wr_data   = rd_entry;
               wr_ptr_in = wr_ptr_ff + 1'b1;
               note_en   = 1'b1;
               note_kind = rd_entry.idx[IDX_W-1:1];
               if (rd_entry.device == dev_ff) begin
                  present_in[rd_entry.idx] = 1'b1;
               end
            end
            if (!scan_more && !pend_ff) begin
               // pairs already down are not pushed again
               add_in   = add_ff & ~present_ff;
               state_in = ST_APPEND;
            end
         end

         ST_APPEND: begin
            // one key a cycle, lowest table index first
            if (add_ff == '0) begin
               state_in = ST_REFRESH;
            end else begin
               add_in = add_ff & ~low_bit;
               if (wr_ptr_ff < CNT_W'(DOWN_DEPTH)) begin
                  wr_en     = 1'b1;
                  wr_data   = '{device: dev_ff, idx: low_idx};
                  wr_ptr_in = wr_ptr_ff + 1'b1;
                  note_en   = 1'b1;
                  note_kind = low_idx[IDX_W-1:1];
               end else begin
                  ovf_in = 1'b1;
               end
            end
         end

         ST_REFRESH: begin
            if (commit) begin
               count_in = wr_ptr_ff;
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // first occurrence of a kind in the new down list
      if (note_en && !seen_ff[note_kind]) begin
         seen_in[note_kind]             = 1'b1;
         order_in[order_len_ff[KIND_W-1:0]] = note_kind;
         order_len_in                   = order_len_ff + 1'b1;
      end
   end

   // response register: filled at commit, emptied when taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      dev_ff       <= dev_in;
      kill_ff      <= kill_in;
      add_ff       <= add_in;
      present_ff   <= present_in;
      taken_ff     <= taken_in;
      ovf_ff       <= ovf_in;
      rd_ptr_ff    <= rd_ptr_in;
      wr_ptr_ff    <= wr_ptr_in;
      seen_ff      <= seen_in;
      order_ff     <= order_in;
      order_len_ff <= order_len_in;
      if (commit) begin
         rpt_ff       <= held_rpt;
         rsp_taken_ff <= taken_ff;
         rsp_ovf_ff   <= ovf_ff;
      end
   end

   // down list storage
   omt_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (DOWN_DEPTH)
   ) u_down_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (ENTRY_W'(wr_data)),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // held kinds
   assign held_ctl.commit    = commit;
   assign held_ctl.seen      = seen_ff;
   assign held_ctl.order     = order_ff;
   assign held_ctl.order_len = order_len_ff;

   omt_held u_held (
      .clock (clock),
      .reset (reset),
      .ctl   (held_ctl),
      .rpt   (held_rpt)
   );

   // response word
   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.changed     = rpt_ff.changed;
   assign rsp_ch.held_count  = rpt_ff.count;
   assign rsp_ch.held_first  = rpt_ff.list[0];
   assign rsp_ch.held_second = rpt_ff.list[1];
   assign rsp_ch.held_third  = rpt_ff.list[2];
   assign rsp_ch.held_fourth = rpt_ff.list[3];
   assign rsp_ch.taken_flag  = rsp_taken_ff;
   assign rsp_ch.overflow    = rsp_ovf_ff;

   // compaction never overtakes the read side
   a_wr_behind_rd: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN && pend_ff) |-> (wr_ptr_ff < rd_ptr_ff))
      else $error("down list write pointer passed read pointer");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DOWN_DEPTH))
      else $error("down count above depth");

   a_ovf_full: assert property (@(posedge clock) disable iff (reset)
      (commit && ovf_ff) |-> (wr_ptr_ff == CNT_W'(DOWN_DEPTH)))
      else $error("overflow flagged with room in down list");

   a_held_matches: assert property (@(posedge clock) disable iff (reset)
      commit |-> (held_rpt.count == HLEN_W'($countones(seen_ff))))
      else $error("held length differs from kinds produced");

   a_commit_rsp: assert property (@(posedge clock) disable iff (reset)
      commit |=> rsp_ch.valid)
      else $error("committed item gave no response");

endmodule

// ===== hdl/omt_ram.sv =====
// ----------------------------------------------------------------------------
// omt_ram
// simple dual port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module omt_ram #(
   parameter int unsigned WIDTH = 11,
   parameter int unsigned DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// ===== hdl/omt_held.sv =====
// ----------------------------------------------------------------------------
// omt_held
// stable ordered list of held modifier kinds and its change report
// ----------------------------------------------------------------------------
module omt_held import omt_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  held_ctl_type ctl,
   output held_rpt_type rpt
);

   logic [MAX_HELD-1:0][KIND_W-1:0] held_ff, held_in;
   logic [HLEN_W-1:0]               len_ff, len_in;

   logic [MAX_HELD-1:0][KIND_W-1:0] cur_list;
   logic                            listed;

   always_comb begin
      held_in = '0;
      len_in  = '0;
      listed  = 1'b0;
      // drop kinds no longer produced, keep the rest in their order
      for (int i = 0; i < MAX_HELD; i++) begin
         if (HLEN_W'(i) < len_ff && ctl.seen[held_ff[i]]) begin
            held_in[len_in[1:0]] = held_ff[i];
            len_in = len_in + 1'b1;
         end
      end
      // append newly produced kinds in down list order
      for (int j = 0; j < MAX_HELD; j++) begin
         listed = 1'b0;
         for (int k = 0; k < MAX_HELD; k++) begin
            if (HLEN_W'(k) < len_ff && held_ff[k] == ctl.order[j]) begin
               listed = 1'b1;
            end
         end
         if (HLEN_W'(j) < ctl.order_len && !listed && len_in < HLEN_W'(MAX_HELD)) begin
            held_in[len_in[1:0]] = ctl.order[j];
            len_in = len_in + 1'b1;
         end
      end
      // current list with unused slots as zero
      for (int i = 0; i < MAX_HELD; i++) begin
         cur_list[i] = (HLEN_W'(i) < len_ff) ? held_ff[i] : '0;
      end
   end

   assign rpt.changed = (len_in != len_ff) || (held_in != cur_list);
   assign rpt.count   = len_in;
   assign rpt.list    = held_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= '0;
      end else if (ctl.commit) begin
         len_ff <= len_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.commit) begin
         held_ff <= held_in;
      end
   end

endmodule

// ===== sim/omt_tracker_checker.sv =====
// ----------------------------------------------------------------------------
// omt_tracker_checker
// watches the request and response channels of the modifier tracker, keeps
// its own copy of the down list and the held list, and compares every
// response word with the report predicted for the oldest request word
// ----------------------------------------------------------------------------
module omt_tracker_checker import omt_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_ready,
   input  logic [FUNC_W-1:0] req_func,
   input  logic [DEV_W-1:0]  req_device,
   input  logic [CODE_W-1:0] req_key_code,
   input  logic [7:0]        req_down_mask,
   input  logic              req_key_taken,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  logic              rsp_changed,
   input  logic [HLEN_W-1:0] rsp_held_count,
   input  logic [KIND_W-1:0] rsp_held_first,
   input  logic [KIND_W-1:0] rsp_held_second,
   input  logic [KIND_W-1:0] rsp_held_third,
   input  logic [KIND_W-1:0] rsp_held_fourth,
   input  logic              rsp_taken_flag,
   input  logic              rsp_overflow,
   output int                mismatches,
   output int                outstanding,
   output int                reports_seen,
   output int                overflows_seen,
   output int                changes_seen
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic                            changed;
      logic [HLEN_W-1:0]               count;
      logic [MAX_HELD-1:0][KIND_W-1:0] kinds;
      logic                            taken;
      logic                            overflow;
   } held_report_type;

   // tracker state as the block should hold it
   logic [DEV_W-1:0]  dl_dev [DOWN_DEPTH];
   logic [IDX_W-1:0]  dl_idx [DOWN_DEPTH];
   int                dl_count;
   logic [KIND_W-1:0] held [MAX_HELD];
   int                held_len;

   held_report_type   due_reports [$];
   held_report_type   due;
   held_report_type   rep;

   // table index of a key code, NUM_KEYS when it is no modifier
   function automatic int key_index(input logic [CODE_W-1:0] code);
      for (int i = 0; i < NUM_KEYS; i++) begin
         if (code == KEY_TABLE[i]) return i;
      end
      return NUM_KEYS;
   endfunction

   function automatic bit pair_down(input logic [DEV_W-1:0] dev, input int k);
      for (int i = 0; i < dl_count; i++) begin
         if (dl_dev[i] == dev && dl_idx[i] == IDX_W'(k)) return 1'b1;
      end
      return 1'b0;
   endfunction

   // zero when the list is full and the pair is dropped
   function automatic bit append_pair(input logic [DEV_W-1:0] dev, input int k);
      if (dl_count >= DOWN_DEPTH) return 1'b0;
      dl_dev[dl_count] = dev;
      dl_idx[dl_count] = IDX_W'(k);
      dl_count++;
      return 1'b1;
   endfunction

   function automatic void drop_pairs(input logic [DEV_W-1:0] dev, input logic [7:0] kill);
      int w;
      w = 0;
      for (int r = 0; r < dl_count; r++) begin
         if (!(dl_dev[r] == dev && kill[dl_idx[r]])) begin
            dl_dev[w] = dl_dev[r];
            dl_idx[w] = dl_idx[r];
            w++;
         end
      end
      dl_count = w;
   endfunction

   // stable update of the held kinds, returns one when the list changed
   function automatic bit refresh_held();
      logic [KIND_W-1:0] fresh [MAX_HELD];
      logic [KIND_W-1:0] prior [MAX_HELD];
      bit                present [MAX_HELD];
      int                fresh_len;
      int                prior_len;
      int                w;
      int                kind;
      bit                listed;
      fresh_len = 0;
      prior_len = held_len;
      w = 0;
      for (int i = 0; i < MAX_HELD; i++) begin
         present[i] = 1'b0;
         prior[i]   = held[i];
         fresh[i]   = '0;
      end
      for (int i = 0; i < dl_count; i++) begin
         kind = int'(dl_idx[i][IDX_W-1:1]);
         if (!present[kind]) begin
            present[kind]    = 1'b1;
            fresh[fresh_len] = KIND_W'(kind);
            fresh_len++;
         end
      end
      for (int i = 0; i < held_len; i++) begin
         if (present[held[i]]) begin
            held[w] = held[i];
            w++;
         end
      end
      held_len = w;
      for (int i = 0; i < fresh_len; i++) begin
         listed = 1'b0;
         for (int j = 0; j < held_len; j++) begin
            if (held[j] == fresh[i]) listed = 1'b1;
         end
         if (!listed && held_len < MAX_HELD) begin
            held[held_len] = fresh[i];
            held_len++;
         end
      end
      if (held_len != prior_len) return 1'b1;
      for (int i = 0; i < held_len; i++) begin
         if (held[i] != prior[i]) return 1'b1;
      end
      return 1'b0;
   endfunction

   task automatic predict_report(input func_type op, input logic [DEV_W-1:0] dev,
                                 input logic [CODE_W-1:0] code, input logic [7:0] mask,
                                 input logic taken, output held_report_type r);
      int k;
      bit ovf;
      k = key_index(code);
      ovf = 1'b0;
      case (op)
         FUNC_PRESS: begin
            if (k < NUM_KEYS && !pair_down(dev, k)) ovf = !append_pair(dev, k);
         end
         FUNC_RELEASE: begin
            if (k < NUM_KEYS) drop_pairs(dev, 8'(1 << k));
         end
         FUNC_FORGET: begin
            drop_pairs(dev, 8'hFF);
         end
         default: begin
            // removals first, then appends in table order
            drop_pairs(dev, ~mask);
            for (int i = 0; i < NUM_KEYS; i++) begin
               if (mask[i] && !pair_down(dev, i)) begin
                  if (!append_pair(dev, i)) ovf = 1'b1;
               end
            end
         end
      endcase
      r.changed = refresh_held();
      r.count   = HLEN_W'(held_len);
      for (int i = 0; i < MAX_HELD; i++) begin
         r.kinds[i] = (i < held_len) ? held[i] : '0;
      end
      r.taken    = taken;
      r.overflow = ovf;
   endtask

   task automatic check_field(input string field, input int want, input int got);
      if (want != got) begin
         mismatches++;
         $display("%0t: %s expected %0d got %0d", $time, field, want, got);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         dl_count = 0;
         held_len = 0;
         for (int i = 0; i < MAX_HELD; i++) held[i] = '0;
         due_reports.delete();
         outstanding = 0;
      end else begin
         if (req_valid && req_ready) begin
            predict_report(func_type'(req_func), req_device, req_key_code, req_down_mask,
                           req_key_taken, rep);
            due_reports.insert(due_reports.size(), rep);
         end
         if (rsp_valid && rsp_ready) begin
            reports_seen++;
            if (due_reports.size() == 0) begin
               mismatches++;
               $display("%0t: response word with no request word waiting for it", $time);
            end else begin
               due = due_reports.pop_front();
               if (due.overflow) overflows_seen++;
               if (due.changed) changes_seen++;
               check_field("changed", due.changed, rsp_changed);
               check_field("held_count", due.count, rsp_held_count);
               check_field("held_first", due.kinds[0], rsp_held_first);
               check_field("held_second", due.kinds[1], rsp_held_second);
               check_field("held_third", due.kinds[2], rsp_held_third);
               check_field("held_fourth", due.kinds[3], rsp_held_fourth);
               check_field("taken_flag", due.taken, rsp_taken_flag);
               check_field("overflow", due.overflow, rsp_overflow);
            end
         end
         outstanding = due_reports.size();
      end
   end

endmodule

// ===== sim/ordered_modifier_tracker_core_test.sv =====
// ----------------------------------------------------------------------------
// ordered_modifier_tracker_core_test
// drives press, release, forget and reconcile words into the tracker with
// random gaps and response stalls; a checker beside the block predicts and
// compares every response word, and this module gives the verdict
// ----------------------------------------------------------------------------
module ordered_modifier_tracker_core_test;
   import omt_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int TARGET_WORDS = 1600;
   localparam int DRAIN_WAIT   = 40;    // well past the longest walk of the down list
   localparam int STALL_LIMIT  = 2000;  // cycles with no word moving on either side

   logic clock;
   logic reset;
   bit   quiet;                         // no gaps and no stalls while set

   int   mismatches;
   int   outstanding;
   int   reports_seen;
   int   overflows_seen;
   int   changes_seen;
   int   sent_ops [4];
   int   idle_cycles;

   omt_req_if req_ch ();
   omt_rsp_if rsp_ch ();

   ordered_modifier_tracker_core uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   omt_tracker_checker checker_i (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_ch.valid),
      .req_ready       (req_ch.ready),
      .req_func        (req_ch.func),
      .req_device      (req_ch.device),
      .req_key_code    (req_ch.key_code),
      .req_down_mask   (req_ch.down_mask),
      .req_key_taken   (req_ch.key_taken),
      .rsp_valid       (rsp_ch.valid),
      .rsp_ready       (rsp_ch.ready),
      .rsp_changed     (rsp_ch.changed),
      .rsp_held_count  (rsp_ch.held_count),
      .rsp_held_first  (rsp_ch.held_first),
      .rsp_held_second (rsp_ch.held_second),
      .rsp_held_third  (rsp_ch.held_third),
      .rsp_held_fourth (rsp_ch.held_fourth),
      .rsp_taken_flag  (rsp_ch.taken_flag),
      .rsp_overflow    (rsp_ch.overflow),
      .mismatches      (mismatches),
      .outstanding     (outstanding),
      .reports_seen    (reports_seen),
      .overflows_seen  (overflows_seen),
      .changes_seen    (changes_seen)
   );

   // 10 ns clock
   initial clock = 1'b0;
   always #5 clock = ~clock;

   // response side: stalls with a chance of about 8 in a hundred
   always @(negedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= quiet || ($urandom_range(99) >= 8);
      end
   end

   // watchdog on cycles with no word accepted anywhere
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // one request word, held until the block takes it; may open with a gap
   task automatic send_word(input func_type op, input logic [DEV_W-1:0] dev,
                            input logic [CODE_W-1:0] code, input logic [7:0] mask,
                            input logic taken);
      int gap;
      if (!quiet && $urandom_range(99) < 8) begin
         gap = $urandom_range(1, 6);
         @(negedge clock);
         req_ch.valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_ch.valid     <= 1'b1;
      req_ch.func      <= op;
      req_ch.device    <= dev;
      req_ch.key_code  <= code;
      req_ch.down_mask <= mask;
      req_ch.key_taken <= taken;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      sent_ops[int'(op)]++;
   endtask

   // drop valid and wait until every report has come back
   task automatic drain_reports();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
   endtask

   initial begin
      int               useful;
      int               blk;
      int               last_blk;
      int               roll;
      int               press_w;
      int               release_w;
      int               forget_w;
      int               next_pause;
      func_type         op;
      logic [DEV_W-1:0] dev;
      logic [DEV_W-1:0] dev_pool [3];
      logic [CODE_W-1:0] code;
      logic [7:0]       mask;

      // every input known from time zero
      reset            = 1'b1;
      quiet            = 1'b0;
      idle_cycles      = 0;
      req_ch.valid     = 1'b0;
      req_ch.func      = FUNC_PRESS;
      req_ch.device    = '0;
      req_ch.key_code  = '0;
      req_ch.down_mask = '0;
      req_ch.key_taken = 1'b0;
      rsp_ch.ready     = 1'b0;
      repeat (3) @(negedge clock);
      reset <= 1'b0;

      // directed: extremes, every operation, special cases
      send_word(FUNC_PRESS, 8'd0, SUPER_L_CODE, 8'h00, 1'b1);
      send_word(FUNC_PRESS, 8'd0, SUPER_L_CODE, 8'h00, 1'b0);    // repeated press
      send_word(FUNC_PRESS, 8'd0, 10'd0, 8'h00, 1'b1);           // not a modifier
      send_word(FUNC_PRESS, 8'd255, CTRL_R_CODE, 8'hFF, 1'b0);
      send_word(FUNC_PRESS, 8'd0, ALT_L_CODE, 8'h00, 1'b1);
      send_word(FUNC_PRESS, 8'd1, SHIFT_R_CODE, 8'h00, 1'b0);    // all four kinds held
      send_word(FUNC_PRESS, 8'd1, 10'd767, 8'h00, 1'b1);
      send_word(FUNC_RELEASE, 8'd7, SHIFT_L_CODE, 8'h00, 1'b0);  // nothing to release
      send_word(FUNC_RELEASE, 8'd0, SUPER_L_CODE, 8'h00, 1'b1);  // others keep their order
      send_word(FUNC_PRESS, 8'd2, SUPER_R_CODE, 8'h00, 1'b0);    // super goes to the end
      send_word(FUNC_RELEASE, 8'd1, 10'd5, 8'h00, 1'b1);
      send_word(FUNC_FORGET, 8'd9, 10'd0, 8'h00, 1'b0);          // unknown device
      send_word(FUNC_FORGET, 8'd0, 10'd0, 8'h00, 1'b1);
      send_word(FUNC_RECONCILE, 8'd3, 10'd0, 8'hFF, 1'b0);       // appends in table order
      send_word(FUNC_RECONCILE, 8'd3, 10'd0, 8'h00, 1'b1);
      send_word(FUNC_RECONCILE, 8'd255, 10'd0, 8'hA5, 1'b0);
      send_word(FUNC_RECONCILE, 8'd20, 10'd0, 8'hFF, 1'b1);
      send_word(FUNC_RECONCILE, 8'd21, 10'd0, 8'hFF, 1'b0);      // list runs full
      send_word(FUNC_PRESS, 8'd22, CTRL_L_CODE, 8'h00, 1'b1);    // press on a full list
      send_word(FUNC_RECONCILE, 8'd20, 10'd0, 8'hF0, 1'b0);      // removals free four
      send_word(FUNC_RECONCILE, 8'd23, 10'd0, 8'hFF, 1'b1);      // partly dropped
      send_word(FUNC_FORGET, 8'd20, 10'd0, 8'h00, 1'b0);
      send_word(FUNC_FORGET, 8'd21, 10'd0, 8'h00, 1'b1);
      send_word(FUNC_FORGET, 8'd23, 10'd0, 8'h00, 1'b0);
      send_word(FUNC_FORGET, 8'd255, 10'd0, 8'h00, 1'b1);
      drain_reports();

      // random part: blocks of a hundred words with their own mix and devices
      useful     = 0;
      last_blk   = -1;
      next_pause = 400;
      while (useful < TARGET_WORDS) begin
         blk = useful / 100;
         if (blk != last_blk) begin
            last_blk = blk;
            for (int i = 0; i < 3; i++) dev_pool[i] = DEV_W'($urandom_range(255));
            quiet = (blk == 5 || blk == 6);
            case (blk % 4)
               0:       begin press_w = 60; release_w = 20; forget_w = 5;  end  // fill up
               1:       begin press_w = 40; release_w = 35; forget_w = 10; end
               2:       begin press_w = 20; release_w = 45; forget_w = 20; end  // empty out
               default: begin press_w = 30; release_w = 25; forget_w = 10; end  // reconcile heavy
            endcase
         end
         if (useful >= next_pause) begin
            drain_reports();
            next_pause += 400;
         end

         roll = $urandom_range(99);
         if (roll < press_w) op = FUNC_PRESS;
         else if (roll < press_w + release_w) op = FUNC_RELEASE;
         else if (roll < press_w + release_w + forget_w) op = FUNC_FORGET;
         else op = FUNC_RECONCILE;

         if ($urandom_range(99) < 80) dev = dev_pool[$urandom_range(2)];
         else dev = DEV_W'($urandom_range(255));

         if ($urandom_range(99) < 88) code = KEY_TABLE[$urandom_range(NUM_KEYS - 1)];
         else code = CODE_W'($urandom_range(767));

         roll = $urandom_range(99);
         if (roll < 15) mask = 8'hFF;
         else if (roll < 25) mask = 8'h00;
         else mask = 8'($urandom_range(255));

         send_word(op, dev, code, mask, 1'($urandom_range(1)));
         useful++;
      end

      drain_reports();
      repeat (DRAIN_WAIT) @(negedge clock);

      $display("request words: %0d press, %0d release, %0d forget, %0d reconcile",
               sent_ops[0], sent_ops[1], sent_ops[2], sent_ops[3]);
      $display("response words checked: %0d, %0d with a dropped push, %0d with a new held list",
               reports_seen, overflows_seen, changes_seen);
      if (mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
